[rtl/core/multilevel_fifo_wrap_dequeue_macros.svh]
// ----------------------------------------------------------------------------
// Multilevel FIFO assertion macros
// Shared property wrappers for the multilevel FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FIFO_WRAP_DEQUEUE_MACROS_SVH
`define MULTILEVEL_FIFO_WRAP_DEQUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MLFQ_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MLFQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, codes and widths shared by the multilevel FIFO modules.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int DEF_MAX_LEVELS  = 8;
	localparam int DEF_LEVEL_DEPTH = 16;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam int LEVEL_W  = 3;
	localparam int ITEM_W   = 32;
	localparam int CFG_W    = 4;
	localparam int STATUS_W = 2;
	localparam int CNT_N_W  = 6;   // holds a level count up to 63

	localparam int IN_FIELDS_W  = LEVEL_W + ITEM_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = LEVEL_W + ITEM_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_LEVEL = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch the incoming request
		logic commit_enq;  // write entry, advance tail, bump count
		logic commit_deq;  // read entry, advance head, drop count
		logic load_res;    // load result with a status-only answer
		logic load_rd;     // load result with the read word
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_deq;
		logic bad;
		logic full;
		logic hit;
	} sts_t;

endpackage

[rtl/core/mlfq_dp.sv]
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: request latch, per-level pointers and counts, entry memory,
// rotated level search and result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
	parameter int MAX_LEVELS  = mlfq_pkg::DEF_MAX_LEVELS,
	parameter int LEVEL_DEPTH = mlfq_pkg::DEF_LEVEL_DEPTH,
	parameter int DATA_WIDTH  = mlfq_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mlfq_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_req_type,
	input  logic [mlfq_pkg::LEVEL_W-1:0]  in_level,
	input  logic [mlfq_pkg::ITEM_W-1:0]   in_item,
	input  mlfq_pkg::cmd_t                cmd,
	output mlfq_pkg::sts_t                sts,
	output mlfq_pkg::status_t             res_status,
	output logic [mlfq_pkg::LEVEL_W-1:0]  res_level,
	output logic [mlfq_pkg::ITEM_W-1:0]   res_item
);
	import mlfq_pkg::*;

	localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W = LVL_W + PTR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(LEVEL_DEPTH - 1);
	localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(LEVEL_DEPTH);
	localparam logic [CNT_N_W-1:0] MAX_LVL_N = CNT_N_W'(MAX_LEVELS);

	logic [CFG_W-1:0]      levels_q;
	logic                  req_deq_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [DATA_WIDTH-1:0] item_q;

	logic [PTR_W-1:0] head_q  [MAX_LEVELS];
	logic [PTR_W-1:0] tail_q  [MAX_LEVELS];
	logic [CNT_W-1:0] count_q [MAX_LEVELS];

	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [LVL_W-1:0]      found_q;

	status_t            status_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [ITEM_W-1:0]  out_item_q;

	logic [CNT_N_W-1:0]    act_n;
	logic [CNT_N_W-1:0]    lvl_ext;
	logic [LVL_W-1:0]      lvl_idx;
	logic [MAX_LEVELS-1:0] cand;
	logic [MAX_LEVELS-1:0] upper;
	logic [LVL_W-1:0]      sel_upper;
	logic [LVL_W-1:0]      sel_any;
	logic [LVL_W-1:0]      sel;
	logic                  bad;
	logic                  full;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [CNT_N_W-1:0]    found_ext;
	logic [63:0]           rd_ext;

	// configuration and request latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= CFG_RESET;
		end else if (cfg_we) begin
			levels_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_deq_q <= in_req_type;
			level_q   <= in_level;
			item_q    <= DATA_WIDTH'(in_item);
		end
	end

	// effective level count, clamped to the built levels
	assign act_n   = ({2'b00, levels_q} > MAX_LVL_N) ? MAX_LVL_N : {2'b00, levels_q};
	assign lvl_ext = CNT_N_W'(level_q);
	assign lvl_idx = lvl_ext[LVL_W-1:0];
	assign bad     = lvl_ext >= act_n;
	assign full    = count_q[lvl_idx] == FULL_CNT;

	// rotated search: first candidate at or above the start level, else the lowest
	always_comb begin
		sel_upper = '0;
		sel_any   = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			cand[i]  = (CNT_N_W'(i) < act_n) && (count_q[i] != '0);
			upper[i] = cand[i] && (CNT_N_W'(i) >= lvl_ext);
		end
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (upper[i]) begin
				sel_upper = LVL_W'(i);
			end
			if (cand[i]) begin
				sel_any = LVL_W'(i);
			end
		end
	end

	assign sel = (|upper) ? sel_upper : sel_any;

	assign sts.is_deq = (req_deq_q == REQ_DEQ);
	assign sts.bad    = bad;
	assign sts.full   = full;
	assign sts.hit    = |cand;

	assign wr_addr = {lvl_idx, tail_q[lvl_idx]};
	assign rd_addr = {sel, head_q[sel]};

	// per-level pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (cmd.commit_enq) begin
			tail_q[lvl_idx]  <= (tail_q[lvl_idx] == LAST_PTR) ? '0 : tail_q[lvl_idx] + 1'b1;
			count_q[lvl_idx] <= count_q[lvl_idx] + 1'b1;
		end else if (cmd.commit_deq) begin
			head_q[sel]  <= (head_q[sel] == LAST_PTR) ? '0 : head_q[sel] + 1'b1;
			count_q[sel] <= count_q[sel] - 1'b1;
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.commit_enq) begin
			mem[wr_addr] <= item_q;
		end
		if (cmd.commit_deq) begin
			rd_data_q <= mem[rd_addr];
			found_q   <= sel;
		end
	end

	assign found_ext = CNT_N_W'(found_q);
	assign rd_ext    = 64'(rd_data_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_rd) begin
			status_q    <= STAT_OK;
			out_level_q <= found_ext[LEVEL_W-1:0];
			out_item_q  <= rd_ext[ITEM_W-1:0];
		end else if (cmd.load_res) begin
			if (bad) begin
				status_q <= STAT_BAD_LEVEL;
			end else if (req_deq_q == REQ_DEQ) begin
				status_q <= STAT_EMPTY;
			end else if (full) begin
				status_q <= STAT_FULL;
			end else begin
				status_q <= STAT_OK;
			end
			out_level_q <= '0;
			out_item_q  <= '0;
		end
	end

	assign res_status = status_q;
	assign res_level  = out_level_q;
	assign res_item   = out_item_q;

endmodule

[rtl/core/mlfq_ctrl.sv]
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Request sequencer: accept, execute, memory read, and result handshake.
// ----------------------------------------------------------------------------
`include "multilevel_fifo_wrap_dequeue_macros.svh"

module mlfq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mlfq_pkg::sts_t sts,
	output mlfq_pkg::cmd_t cmd
);
	import mlfq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;
	logic   load;

	// result slot is free if empty or draining this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					if (sts.bad || !sts.is_deq) begin
						cmd.commit_enq = !sts.bad && !sts.full;
						cmd.load_res   = 1'b1;
						state_nxt      = ST_IDLE;
					end else if (sts.hit) begin
						cmd.commit_deq = 1'b1;
						state_nxt      = ST_READ;
					end else begin
						cmd.load_res = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.load_rd = 1'b1;
				state_nxt   = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign load = cmd.load_res || cmd.load_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MLFQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC, "accept did not enter execute")
	`MLFQ_ASSERT_SAME(a_read_slot_free, clk, arst_n, state_q == ST_READ, !out_valid_q, "read stage found result slot busy")
	`MLFQ_ASSERT_SAME(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready, !load, "pending result overwritten")
	`MLFQ_ASSERT_NEXT(a_deq_then_read, clk, arst_n, cmd.commit_deq, state_q == ST_READ && !out_valid_q, "dequeue not followed by read")

endmodule

[rtl/core/multilevel_fifo_wrap_dequeue.sv]
// ----------------------------------------------------------------------------
// multilevel_fifo_wrap_dequeue
// Multilevel FIFO with per-level queues and a wrapping dequeue search.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: req_type; tdata: level, item_in
// m_axis    out  tvalid/tready          tuser: status;   tdata: found_level, item_out
// cfg       in   cfg_valid/cfg_ready    cfg_data: levels_in_use
//
// Enqueue and rejected requests go through accept, then execute with result
// load; a dequeue that finds a word goes through accept, pointer update with
// memory read, then result load; the single-port memory read is registered.
// Reset clears pointers and counts and sets levels_in_use to 8, not memory.
// The result register holds while m_axis_tready is low; a new request may be
// accepted meanwhile, and its execution waits for the register to free.
// ----------------------------------------------------------------------------
module multilevel_fifo_wrap_dequeue #(
	parameter int MAX_LEVELS  = mlfq_pkg::DEF_MAX_LEVELS,
	parameter int LEVEL_DEPTH = mlfq_pkg::DEF_LEVEL_DEPTH,
	parameter int DATA_WIDTH  = mlfq_pkg::DEF_DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mlfq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // level, item_in
	input  logic                              s_axis_tuser,  // req_type
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mlfq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // found_level, item_out
	output logic [mlfq_pkg::STATUS_W-1:0]     m_axis_tuser,  // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mlfq_pkg::CFG_W-1:0]        cfg_data
);
	import mlfq_pkg::*;

	localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

	cmd_t               cmd;
	sts_t               sts;
	status_t            res_status;
	logic [LEVEL_W-1:0] res_level;
	logic [ITEM_W-1:0]  res_item;

	assign cfg_ready = 1'b1;

	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mlfq_dp #(
		.MAX_LEVELS  (MAX_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_data    (cfg_data),
		.in_req_type (s_axis_tuser),
		.in_level    (s_axis_tdata[LEVEL_W-1:0]),
		.in_item     (s_axis_tdata[IN_FIELDS_W-1:LEVEL_W]),
		.cmd         (cmd),
		.sts         (sts),
		.res_status  (res_status),
		.res_level   (res_level),
		.res_item    (res_item)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_item, res_level};
	assign m_axis_tuser = res_status;

endmodule
